// File: rtl/core/hbm_pkg.sv
// ----------------------------------------------------------------------------
// hbm_pkg
// Shared types and constants of the height-binned mean unit: beat payloads,
// operation codes, fixed field widths and parameter defaults.
// ----------------------------------------------------------------------------
package hbm_pkg;

   localparam int NUM_BINS_DEF   = 64;
   localparam int COUNT_BITS_DEF = 24;

   localparam int HEIGHT_W  = 24;
   localparam int VEL_W     = 16;
   localparam int TEMP_W    = 16;
   localparam int SUM_W     = 40;
   localparam int BIN_IDX_W = 6;
   localparam int BIN_H_W   = 30;
   localparam int DROP_W    = 24;
   localparam int BIN_CNT_W = 7;
   localparam int MEAN_W    = 16;

   localparam logic OP_ACCUM = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // Register indexes; byte address is index times four.
   localparam logic [1:0] REG_HEIGHT_MIN  = 2'd0;
   localparam logic [1:0] REG_BIN_SPACING = 2'd1;
   localparam logic [1:0] REG_BIN_COUNT   = 2'd2;

   typedef struct packed {
      logic                     opcode;
      logic [HEIGHT_W-1:0]      height;
      logic signed [VEL_W-1:0]  vel_x;
      logic signed [VEL_W-1:0]  vel_y;
      logic signed [VEL_W-1:0]  vel_z;
      logic [TEMP_W-1:0]        temperature;
   } req_type;

   typedef struct packed {
      logic [BIN_IDX_W-1:0]     bin_index;
      logic [BIN_H_W-1:0]       bin_height;
      logic signed [MEAN_W-1:0] mean_x;
      logic signed [MEAN_W-1:0] mean_y;
      logic signed [MEAN_W-1:0] mean_z;
      logic [MEAN_W-1:0]        mean_temp;
      logic                     bin_empty;
      logic [DROP_W-1:0]        dropped;
      logic                     last;
   } rsp_type;

   // One bin's sums handed to the mean divider.
   typedef struct packed {
      logic signed [SUM_W-1:0] sum_x;
      logic signed [SUM_W-1:0] sum_y;
      logic signed [SUM_W-1:0] sum_z;
      logic [SUM_W-1:0]        sum_t;
   } div_sums_type;

   typedef struct packed {
      logic signed [MEAN_W-1:0] mean_x;
      logic signed [MEAN_W-1:0] mean_y;
      logic signed [MEAN_W-1:0] mean_z;
      logic [MEAN_W-1:0]        mean_t;
   } div_means_type;

endpackage

// File: rtl/core/hbm_mean_div.sv
// ----------------------------------------------------------------------------
// hbm_mean_div
// Four-lane restoring divider: divides three signed sums and one unsigned sum
// by a shared count, one quotient bit per cycle, truncating toward zero and
// clamping to the 16-bit mean range.
// ----------------------------------------------------------------------------
module hbm_mean_div
   import hbm_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  div_sums_type          sums,
   input  logic [COUNT_BITS-1:0] count,
   output logic                  done,
   output div_means_type         means
);

   localparam int LANES  = 4;
   localparam int STEP_W = $clog2(SUM_W);

   logic [SUM_W-1:0]      quo_ff [LANES];
   logic [SUM_W-1:0]      quo_in [LANES];
   logic [COUNT_BITS-1:0] rem_ff [LANES];
   logic [COUNT_BITS-1:0] rem_in [LANES];
   logic [2:0]            neg_ff;
   logic [COUNT_BITS-1:0] cnt_ff;
   logic [STEP_W-1:0]     step_ff;
   logic                  busy_ff;
   logic                  done_ff;

   function automatic logic [SUM_W-1:0] magnitude(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-1:0] r;
      r = v[SUM_W-1] ? (~v + 1'b1) : v;
      return r;
   endfunction

   function automatic logic [MEAN_W-1:0] clamp_signed(input logic [SUM_W-1:0] q,
                                                      input logic neg);
      logic [MEAN_W-1:0] r;
      if (neg) begin
         if (q > SUM_W'(32768)) r = 16'h8000;
         else                   r = ~q[MEAN_W-1:0] + 1'b1;
      end else begin
         if (q > SUM_W'(32767)) r = 16'h7FFF;
         else                   r = q[MEAN_W-1:0];
      end
      return r;
   endfunction

   always_comb begin
      logic [COUNT_BITS:0] sh;
      for (int i = 0; i < LANES; i++) begin
         sh = {rem_ff[i], quo_ff[i][SUM_W-1]};
         if (sh >= {1'b0, cnt_ff}) begin
            rem_in[i] = COUNT_BITS'(sh - {1'b0, cnt_ff});
            quo_in[i] = {quo_ff[i][SUM_W-2:0], 1'b1};
         end else begin
            rem_in[i] = sh[COUNT_BITS-1:0];
            quo_in[i] = {quo_ff[i][SUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff[0] <= magnitude(sums.sum_x);
         quo_ff[1] <= magnitude(sums.sum_y);
         quo_ff[2] <= magnitude(sums.sum_z);
         quo_ff[3] <= sums.sum_t;
         neg_ff    <= {sums.sum_z[SUM_W-1], sums.sum_y[SUM_W-1], sums.sum_x[SUM_W-1]};
         cnt_ff    <= count;
         for (int i = 0; i < LANES; i++) rem_ff[i] <= '0;
      end else if (busy_ff) begin
         for (int i = 0; i < LANES; i++) begin
            quo_ff[i] <= quo_in[i];
            rem_ff[i] <= rem_in[i];
         end
      end
   end

   assign done          = done_ff;
   assign means.mean_x  = clamp_signed(quo_ff[0], neg_ff[0]);
   assign means.mean_y  = clamp_signed(quo_ff[1], neg_ff[1]);
   assign means.mean_z  = clamp_signed(quo_ff[2], neg_ff[2]);
   assign means.mean_t  = (quo_ff[3] > SUM_W'(65535)) ? 16'hFFFF : quo_ff[3][MEAN_W-1:0];

endmodule

// File: rtl/core/height_binned_mean_unit.sv
// ----------------------------------------------------------------------------
// height_binned_mean_unit
// Bins samples by height and keeps per-bin velocity/temperature sums and
// counts in one memory; a drain beat reports per-bin means and clears.
// ----------------------------------------------------------------------------
// Accumulate: range check, 7-step bin-index division, memory read, write back,
//   then idle; a height outside the bins is dropped at the range check or read.
// Drain, per bin: read, load, the 40-step mean divider (skipped for an empty
//   bin) and push, which output stalls hold; a clear state ends the drain.
// Reset: synchronous; clears all bin valid bits, so the store reads as zero at
//   once without a clearing pass. Registers return to min 0, spacing 256, 64 bins.
module height_binned_mean_unit
   import hbm_pkg::*;
#(
   parameter int NUM_BINS   = NUM_BINS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int BIN_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int WORD_W = 4 * SUM_W + COUNT_BITS;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CHK  = 4'd1;
   localparam logic [3:0] S_IDX  = 4'd2;
   localparam logic [3:0] S_RD   = 4'd3;
   localparam logic [3:0] S_WR   = 4'd4;
   localparam logic [3:0] S_DRD  = 4'd5;
   localparam logic [3:0] S_DLD  = 4'd6;
   localparam logic [3:0] S_DDIV = 4'd7;
   localparam logic [3:0] S_PUSH = 4'd8;
   localparam logic [3:0] S_DFIN = 4'd9;

   localparam logic signed [SUM_W-1:0] SMAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SMIN = {1'b1, {(SUM_W-1){1'b0}}};

   // Configuration
   logic [HEIGHT_W-1:0]  hmin_ff;
   logic [HEIGHT_W-1:0]  spc_ff;
   logic [BIN_CNT_W-1:0] bcnt_ff;
   logic                 csr_wr;

   // Control
   logic [3:0]           state_ff;
   req_type              item_ff;
   logic [HEIGHT_W-1:0]  rem_ff;
   logic [HEIGHT_W+6:0]  dv_ff;
   logic [6:0]           quo_ff;
   logic [2:0]           step_ff;
   logic [DROP_W-1:0]    drop_ff;
   logic [NUM_BINS-1:0]  valid_ff;
   logic [BIN_CNT_W-1:0] bin_ff;
   logic [BIN_H_W-1:0]   bh_ff;
   logic                 empty_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   // Memory
   logic [WORD_W-1:0]    bin_mem [NUM_BINS];
   logic [WORD_W-1:0]    mem_rd_ff;
   logic                 mem_re;
   logic                 mem_we;
   logic [BIN_W-1:0]     rd_addr;
   logic [BIN_W-1:0]     acc_idx;
   logic [WORD_W-1:0]    wr_data;

   // Datapath
   logic [HEIGHT_W-1:0]   sp_eff;
   logic [BIN_CNT_W-1:0]  n_use;
   logic [HEIGHT_W-1:0]   diff;
   logic [WORD_W-1:0]     entry;
   logic signed [SUM_W-1:0] cur_x, cur_y, cur_z;
   logic [SUM_W-1:0]      cur_t;
   logic [COUNT_BITS-1:0] cur_cnt;
   logic signed [SUM_W-1:0] new_x, new_y, new_z;
   logic [SUM_W-1:0]      new_t;
   logic                  is_last;
   logic                  out_free;
   logic                  div_start;
   logic                  div_done;
   div_sums_type          div_sums;
   div_means_type         div_means;

   function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                       input logic signed [VEL_W-1:0] b);
      logic [SUM_W:0] s;
      logic signed [SUM_W-1:0] r;
      s = {a[SUM_W-1], a} + {{(SUM_W+1-VEL_W){b[VEL_W-1]}}, b};
      if (s[SUM_W] != s[SUM_W-1]) r = s[SUM_W] ? SMIN : SMAX;
      else                        r = s[SUM_W-1:0];
      return r;
   endfunction

   // ---------------- configuration port ----------------
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_comb begin
      unique case (paddr[3:2])
         REG_HEIGHT_MIN:  prdata = {{(32-HEIGHT_W){1'b0}}, hmin_ff};
         REG_BIN_SPACING: prdata = {{(32-HEIGHT_W){1'b0}}, spc_ff};
         REG_BIN_COUNT:   prdata = {{(32-BIN_CNT_W){1'b0}}, bcnt_ff};
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hmin_ff <= '0;
         spc_ff  <= HEIGHT_W'(256);
         bcnt_ff <= BIN_CNT_W'(64);
      end else if (csr_wr) begin
         unique case (paddr[3:2])
            REG_HEIGHT_MIN:  hmin_ff <= pwdata[HEIGHT_W-1:0];
            REG_BIN_SPACING: spc_ff  <= pwdata[HEIGHT_W-1:0];
            REG_BIN_COUNT:   bcnt_ff <= pwdata[BIN_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- datapath ----------------
   assign sp_eff = (spc_ff == '0) ? HEIGHT_W'(1) : spc_ff;

   always_comb begin
      if (bcnt_ff == '0)                          n_use = BIN_CNT_W'(1);
      else if (bcnt_ff > BIN_CNT_W'(NUM_BINS))    n_use = BIN_CNT_W'(NUM_BINS);
      else                                        n_use = bcnt_ff;
   end

   assign diff    = item_ff.height - hmin_ff;
   assign acc_idx = quo_ff[BIN_W-1:0];
   assign rd_addr = (state_ff == S_RD) ? acc_idx : bin_ff[BIN_W-1:0];
   assign mem_re  = (state_ff == S_RD) || (state_ff == S_DRD);

   // Entries not written since the last drain read as zero.
   always_comb begin
      logic vld;
      vld   = (state_ff == S_WR) ? valid_ff[acc_idx] : valid_ff[bin_ff[BIN_W-1:0]];
      entry = vld ? mem_rd_ff : '0;
   end

   assign cur_x   = entry[SUM_W-1:0];
   assign cur_y   = entry[2*SUM_W-1:SUM_W];
   assign cur_z   = entry[3*SUM_W-1:2*SUM_W];
   assign cur_t   = entry[4*SUM_W-1:3*SUM_W];
   assign cur_cnt = entry[WORD_W-1:4*SUM_W];

   assign new_x = sat_add(cur_x, item_ff.vel_x);
   assign new_y = sat_add(cur_y, item_ff.vel_y);
   assign new_z = sat_add(cur_z, item_ff.vel_z);

   always_comb begin
      logic [SUM_W:0] ts;
      ts    = {1'b0, cur_t} + {{(SUM_W+1-TEMP_W){1'b0}}, item_ff.temperature};
      new_t = ts[SUM_W] ? '1 : ts[SUM_W-1:0];
   end

   // A full count freezes the bin.
   assign mem_we  = (state_ff == S_WR) && !(&cur_cnt);
   assign wr_data = {cur_cnt + 1'b1, new_t, new_z, new_y, new_x};

   always_ff @(posedge clock) begin
      if (mem_we) bin_mem[acc_idx] <= wr_data;
      if (mem_re) mem_rd_ff <= bin_mem[rd_addr];
   end

   assign div_sums.sum_x = cur_x;
   assign div_sums.sum_y = cur_y;
   assign div_sums.sum_z = cur_z;
   assign div_sums.sum_t = cur_t;
   assign div_start      = (state_ff == S_DLD) && (cur_cnt != '0);

   hbm_mean_div #(
      .COUNT_BITS (COUNT_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .sums  (div_sums),
      .count (cur_cnt),
      .done  (div_done),
      .means (div_means)
   );

   assign is_last  = (bin_ff + 1'b1) == n_use;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // ---------------- control ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_PUSH) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         drop_ff      <= '0;
         valid_ff     <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= (req_data.opcode == OP_DRAIN) ? S_DRD : S_CHK;
               end
            end
            S_CHK: begin
               if ((item_ff.height < hmin_ff) ||
                   ({7'd0, diff} >= {sp_eff, 7'd0})) begin
                  if (drop_ff != '1) drop_ff <= drop_ff + 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_IDX;
               end
            end
            S_IDX: begin
               if (step_ff == '0) state_ff <= S_RD;
            end
            S_RD: begin
               if (quo_ff >= n_use) begin
                  if (drop_ff != '1) drop_ff <= drop_ff + 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_WR;
               end
            end
            S_WR: begin
               if (mem_we) valid_ff[acc_idx] <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_DRD:  state_ff <= S_DLD;
            S_DLD:  state_ff <= (cur_cnt == '0) ? S_PUSH : S_DDIV;
            S_DDIV: begin
               if (div_done) state_ff <= S_PUSH;
            end
            S_PUSH: begin
               if (out_free) begin
                  state_ff <= is_last ? S_DFIN : S_DRD;
               end
            end
            S_DFIN: begin
               valid_ff <= '0;
               drop_ff  <= '0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Payload and step registers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         item_ff <= req_data;
         bin_ff  <= '0;
         bh_ff   <= {{(BIN_H_W-HEIGHT_W){1'b0}}, hmin_ff};
      end
      if (state_ff == S_CHK) begin
         rem_ff  <= diff;
         dv_ff   <= {1'b0, sp_eff, 6'd0};
         quo_ff  <= '0;
         step_ff <= 3'd6;
      end
      if (state_ff == S_IDX) begin
         if ({7'd0, rem_ff} >= dv_ff) begin
            rem_ff <= rem_ff - dv_ff[HEIGHT_W-1:0];
            quo_ff <= {quo_ff[5:0], 1'b1};
         end else begin
            quo_ff <= {quo_ff[5:0], 1'b0};
         end
         dv_ff   <= dv_ff >> 1;
         step_ff <= step_ff - 1'b1;
      end
      if (state_ff == S_DLD) empty_ff <= (cur_cnt == '0);
      if (state_ff == S_PUSH && out_free) begin
         rsp_ff.bin_index  <= BIN_IDX_W'(bin_ff);
         rsp_ff.bin_height <= bh_ff;
         rsp_ff.mean_x     <= empty_ff ? '0 : div_means.mean_x;
         rsp_ff.mean_y     <= empty_ff ? '0 : div_means.mean_y;
         rsp_ff.mean_z     <= empty_ff ? '0 : div_means.mean_z;
         rsp_ff.mean_temp  <= empty_ff ? '0 : div_means.mean_t;
         rsp_ff.bin_empty  <= empty_ff;
         rsp_ff.dropped    <= drop_ff;
         rsp_ff.last       <= is_last;
         bin_ff <= bin_ff + 1'b1;
         bh_ff  <= bh_ff + {{(BIN_H_W-HEIGHT_W){1'b0}}, sp_eff};
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------- assertions ----------------
   a_clear_after_drain: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DFIN |=> (valid_ff == '0) && (drop_ff == '0))
      else $error("store not cleared after drain");

   a_write_only_accum: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (quo_ff < n_use) && (item_ff.opcode == OP_ACCUM))
      else $error("memory write outside an in-range accumulate");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUSH) && out_free && is_last |=>
         rsp_data.last && (BIN_CNT_W'(rsp_data.bin_index) + 1'b1 == n_use))
      else $error("last beat carries the wrong bin index");

   a_empty_means_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bin_empty |->
         (rsp_data.mean_x == '0) && (rsp_data.mean_y == '0) &&
         (rsp_data.mean_z == '0) && (rsp_data.mean_temp == '0))
      else $error("empty bin reports nonzero mean");

endmodule

// File: verif/height_binned_mean_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// height_binned_mean_unit_tb
// Streams samples and drain beats into the height-binned mean unit under
// several bin setups, predicts every per-bin mean record and compares each
// output beat field by field, with random idle gaps on both channels.
// ----------------------------------------------------------------------------

class bin_mean_scoreboard;
   localparam int NBINS = hbm_pkg::NUM_BINS_DEF;
   localparam longint SMAX = 64'sd549755813887;
   localparam longint SMIN = -64'sd549755813888;
   localparam longint UMAX = 64'd1099511627775;
   localparam longint CMAX = (64'd1 << hbm_pkg::COUNT_BITS_DEF) - 1;

   longint sum_x[NBINS];
   longint sum_y[NBINS];
   longint sum_z[NBINS];
   longint sum_t[NBINS];
   longint hits[NBINS];
   longint drops;
   longint min_h;
   longint spacing;
   longint nbins;
   hbm_pkg::rsp_type pending_bins[$];
   int errors;

   function new();
      min_h = 0;
      spacing = 256;
      nbins = 64;
      wipe();
   endfunction

   function void wipe();
      for (int b = 0; b < NBINS; b++) begin
         sum_x[b] = 0; sum_y[b] = 0; sum_z[b] = 0; sum_t[b] = 0; hits[b] = 0;
      end
      drops = 0;
   endfunction

   function longint clamp_sum(longint v);
      if (v > SMAX) return SMAX;
      if (v < SMIN) return SMIN;
      return v;
   endfunction

   function logic [15:0] vel_mean(longint s, longint c);
      longint q;
      q = s / c;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   function void note_beat(hbm_pkg::req_type r);
      longint n, sp, h, b, t;
      hbm_pkg::rsp_type o;
      n = (nbins == 0) ? 1 : (nbins > NBINS ? NBINS : nbins);
      sp = (spacing == 0) ? 1 : spacing;
      if (r.opcode == hbm_pkg::OP_ACCUM) begin
         h = r.height;
         if (h < min_h) begin
            if (drops < 24'hFFFFFF) drops++;
            return;
         end
         b = (h - min_h) / sp;
         if (b >= n) begin
            if (drops < 24'hFFFFFF) drops++;
            return;
         end
         if (hits[b] >= CMAX) return;
         hits[b]++;
         sum_x[b] = clamp_sum(sum_x[b] + longint'(r.vel_x));
         sum_y[b] = clamp_sum(sum_y[b] + longint'(r.vel_y));
         sum_z[b] = clamp_sum(sum_z[b] + longint'(r.vel_z));
         t = sum_t[b] + longint'(r.temperature);
         sum_t[b] = (t > UMAX) ? UMAX : t;
         return;
      end
      for (int i = 0; i < n; i++) begin
         o = '0;
         o.bin_index = 6'(i);
         o.bin_height = 30'(min_h + i * sp);
         if (hits[i] == 0) begin
            o.bin_empty = 1'b1;
         end else begin
            o.mean_x = vel_mean(sum_x[i], hits[i]);
            o.mean_y = vel_mean(sum_y[i], hits[i]);
            o.mean_z = vel_mean(sum_z[i], hits[i]);
            t = sum_t[i] / hits[i];
            o.mean_temp = (t > 65535) ? 16'hFFFF : t[15:0];
         end
         o.dropped = 24'(drops);
         o.last = (i + 1 == n);
         pending_bins.push_back(o);
      end
      wipe();
   endfunction

   task report(string what, longint got, longint want);
      $display("bin beat %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   task check_beat(hbm_pkg::rsp_type g);
      hbm_pkg::rsp_type e;
      if (pending_bins.size() == 0) begin
         report("unexpected", g.bin_index, -1);
         return;
      end
      e = pending_bins.pop_front();
      if (g.bin_index !== e.bin_index) report("bin_index", g.bin_index, e.bin_index);
      if (g.bin_height !== e.bin_height) report("bin_height", g.bin_height, e.bin_height);
      if (g.mean_x !== e.mean_x) report("mean_x", g.mean_x, e.mean_x);
      if (g.mean_y !== e.mean_y) report("mean_y", g.mean_y, e.mean_y);
      if (g.mean_z !== e.mean_z) report("mean_z", g.mean_z, e.mean_z);
      if (g.mean_temp !== e.mean_temp) report("mean_temp", g.mean_temp, e.mean_temp);
      if (g.bin_empty !== e.bin_empty) report("bin_empty", g.bin_empty, e.bin_empty);
      if (g.dropped !== e.dropped) report("dropped", g.dropped, e.dropped);
      if (g.last !== e.last) report("last", g.last, e.last);
   endtask
endclass

module height_binned_mean_unit_tb;
   import hbm_pkg::*;

   localparam int STALL_LIMIT = 200000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic psel;
   logic penable;
   logic pwrite;
   logic [3:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   bin_mean_scoreboard sb;
   int quiet_cycles;

   height_binned_mean_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Receiver side: random stall, check every accepted beat.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) sb.check_beat(rsp_data);
         rsp_stall <= ($urandom_range(0, 99) < 25);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task write_reg(logic [1:0] idx, logic [31:0] value);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_HEIGHT_MIN: sb.min_h = value[23:0];
         REG_BIN_SPACING: sb.spacing = value[23:0];
         default: sb.nbins = value[6:0];
      endcase
   endtask

   task send_beat(req_type r);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_beat(r);
   endtask

   task drain_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_bins.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function req_type sample_at(logic [23:0] h);
      req_type r;
      r.opcode = OP_ACCUM;
      r.height = h;
      r.vel_x = 16'($urandom);
      r.vel_y = 16'($urandom);
      r.vel_z = 16'($urandom);
      r.temperature = 16'($urandom);
      return r;
   endfunction

   function req_type drain_beat();
      req_type r;
      r = '0;
      r.opcode = OP_DRAIN;
      r.height = 24'($urandom);
      r.vel_x = 16'($urandom);
      r.temperature = 16'($urandom);
      return r;
   endfunction

   // In-range sample for the current setup, with some misses mixed in.
   function req_type random_sample();
      longint sp, n, h;
      sp = (sb.spacing == 0) ? 1 : sb.spacing;
      n = (sb.nbins == 0) ? 1 : (sb.nbins > 64 ? 64 : sb.nbins);
      if ($urandom_range(0, 9) < 8)
         h = sb.min_h + $urandom_range(0, n - 1) * sp + $urandom_range(0, sp - 1);
      else
         h = $urandom;
      if (h > 24'hFFFFFF) h = $urandom;
      return sample_at(h[23:0]);
   endfunction

   task random_phase(int count);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 99) < 7) send_beat(drain_beat());
         else send_beat(random_sample());
      end
      send_beat(drain_beat());
      drain_quiet();
   endtask

   initial begin
      req_type r;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes at reset setup, below-min, beyond range, empty bins.
      r = sample_at(24'd0);
      r.vel_x = 16'sh7FFF; r.vel_y = 16'sh8000; r.vel_z = -16'sd1; r.temperature = 16'hFFFF;
      send_beat(r);
      r.vel_x = 16'sh8000; r.vel_y = 16'sh7FFF; r.vel_z = 16'sd3; r.temperature = 16'd0;
      send_beat(r);
      r = sample_at(24'd256);
      r.vel_x = -16'sd7; r.vel_y = 16'sd7; r.vel_z = 16'sd0;
      send_beat(r);
      send_beat(sample_at(24'(63 * 256 + 255)));
      send_beat(sample_at(24'(64 * 256)));
      send_beat(sample_at(24'hFFFFFF));
      send_beat(drain_beat());
      drain_quiet();

      write_reg(REG_HEIGHT_MIN, 32'hFFFFFF);
      write_reg(REG_BIN_SPACING, 32'hFFFFFF);
      write_reg(REG_BIN_COUNT, 32'd1);
      send_beat(sample_at(24'hFFFFFE));
      send_beat(sample_at(24'hFFFFFF));
      send_beat(drain_beat());
      drain_quiet();

      write_reg(REG_HEIGHT_MIN, 32'd100);
      write_reg(REG_BIN_SPACING, 32'd0);
      write_reg(REG_BIN_COUNT, 32'd0);
      send_beat(sample_at(24'd100));
      send_beat(sample_at(24'd101));
      send_beat(sample_at(24'd99));
      send_beat(drain_beat());
      drain_quiet();

      write_reg(REG_BIN_COUNT, 32'd127);
      write_reg(REG_BIN_SPACING, 32'd3);
      send_beat(sample_at(24'(100 + 3 * 63 + 2)));
      send_beat(sample_at(24'(100 + 3 * 64)));
      send_beat(drain_beat());
      drain_quiet();

      // Random phases across several setups.
      write_reg(REG_HEIGHT_MIN, 32'd0);
      write_reg(REG_BIN_SPACING, 32'd256);
      write_reg(REG_BIN_COUNT, 32'd8);
      random_phase(35);
      write_reg(REG_HEIGHT_MIN, $urandom_range(0, 24'hFFFF));
      write_reg(REG_BIN_SPACING, $urandom_range(1, 4096));
      write_reg(REG_BIN_COUNT, $urandom_range(1, 6));
      random_phase(35);
      write_reg(REG_HEIGHT_MIN, 32'd5000);
      write_reg(REG_BIN_SPACING, 32'd1);
      write_reg(REG_BIN_COUNT, 32'd2);
      random_phase(30);
      write_reg(REG_HEIGHT_MIN, 32'd0);
      write_reg(REG_BIN_SPACING, 32'h3FFFF);
      write_reg(REG_BIN_COUNT, 32'd64);
      random_phase(30);

      req_valid <= 1'b0;
      if (sb.errors == 0 && sb.pending_bins.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
